/* rtl/core/ccs_pkg.sv */
// Types and fixed widths shared by the circle/segment distance pipeline.
// No dependencies.
package ccs_pkg;

    localparam int CB   = 24;          // coordinate width
    localparam int DW   = CB + 1;      // coordinate difference
    localparam int PW   = 2 * DW;      // signed product
    localparam int SW   = 2 * CB + 2;  // unsigned sum of squares
    localparam int CHL  = CB + 2;      // low part of the cross split
    localparam int CHH  = SW - CHL;    // high part of the cross split
    localparam int NW   = 2 * SW;      // squared distance numerator
    localparam int RB   = CB + 2;      // root bits
    localparam int DAW  = RB + SW;     // root times denominator
    localparam int DELW = NW + 4;      // trial delta
    localparam int OW   = CB + 1;      // distance output

    typedef struct packed {
        logic signed [CB-1:0] point_x;
        logic signed [CB-1:0] point_y;
        logic signed [CB-1:0] seg_start_x;
        logic signed [CB-1:0] seg_start_y;
        logic signed [CB-1:0] seg_end_x;
        logic signed [CB-1:0] seg_end_y;
        logic        [CB-1:0] circle_radius;
    } t_in;

    typedef struct packed {
        logic [OW-1:0] distance;
        logic          collided;
    } t_out;

    typedef struct packed {
        logic           valid;
        logic [NW-1:0]  rem;
        logic [DAW-1:0] dacc;
        logic [SW-1:0]  den;
        logic [RB-1:0]  root;
        logic [CB-1:0]  rad;
    } t_root;

endpackage

/* rtl/core/ccs_front.sv */
// Front pipeline: differences, products, dot/cross tests, squared numerator.
// Uses ccs_pkg. Produces the start value for the root cell chain.
module ccs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ccs_pkg::t_in   i_data,
    output ccs_pkg::t_root o_root
);

    logic [4:0] r_v;

    logic signed [ccs_pkg::DW-1:0] r_vx, r_vy, r_wx, r_wy, r_ux, r_uy;
    logic [ccs_pkg::CB-1:0] r_rad1, r_rad2, r_rad3, r_rad4, r_rad5;

    logic signed [ccs_pkg::PW-1:0] r_pwx, r_pwy, r_pux, r_puy, r_pc1, r_pc2;
    logic [ccs_pkg::SW-1:0] r_wx2, r_wy2, r_ux2, r_uy2, r_vx2, r_vy2;

    logic [ccs_pkg::SW-1:0] r_s1, r_s2, r_vv, r_cmag;
    logic r_inside;

    logic [ccs_pkg::SW-1:0] r_smin, r_den4;
    logic [2*ccs_pkg::CHH-1:0] r_ch2;
    logic [ccs_pkg::CHH+ccs_pkg::CHL-1:0] r_chcl;
    logic [2*ccs_pkg::CHL-1:0] r_cl2;
    logic r_inside4;

    logic [ccs_pkg::NW-1:0] r_num;
    logic [ccs_pkg::SW-1:0] r_den;

    logic signed [ccs_pkg::PW:0] n_dot1, n_dot2, n_cross;
    logic [ccs_pkg::PW:0] n_cabs;
    logic [ccs_pkg::NW-1:0] n_cnum;

    always_comb begin
        n_dot1  = {r_pwx[ccs_pkg::PW-1], r_pwx} + {r_pwy[ccs_pkg::PW-1], r_pwy};
        n_dot2  = {r_pux[ccs_pkg::PW-1], r_pux} + {r_puy[ccs_pkg::PW-1], r_puy};
        n_cross = {r_pc1[ccs_pkg::PW-1], r_pc1} - {r_pc2[ccs_pkg::PW-1], r_pc2};
        n_cabs  = n_cross[ccs_pkg::PW] ? (ccs_pkg::PW+1)'(0) - n_cross : n_cross;
        n_cnum  = ({{(ccs_pkg::NW-2*ccs_pkg::CHH){1'b0}}, r_ch2} << (2*ccs_pkg::CHL))
                + ({{(ccs_pkg::NW-ccs_pkg::CHH-ccs_pkg::CHL){1'b0}}, r_chcl}
                   << (ccs_pkg::CHL+1))
                + {{(ccs_pkg::NW-2*ccs_pkg::CHL){1'b0}}, r_cl2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx   <= ccs_pkg::DW'(i_data.seg_end_x) - ccs_pkg::DW'(i_data.seg_start_x);
            r_vy   <= ccs_pkg::DW'(i_data.seg_end_y) - ccs_pkg::DW'(i_data.seg_start_y);
            r_wx   <= ccs_pkg::DW'(i_data.point_x) - ccs_pkg::DW'(i_data.seg_start_x);
            r_wy   <= ccs_pkg::DW'(i_data.point_y) - ccs_pkg::DW'(i_data.seg_start_y);
            r_ux   <= ccs_pkg::DW'(i_data.point_x) - ccs_pkg::DW'(i_data.seg_end_x);
            r_uy   <= ccs_pkg::DW'(i_data.point_y) - ccs_pkg::DW'(i_data.seg_end_y);
            r_rad1 <= i_data.circle_radius;

            r_pwx  <= r_wx * r_vx;
            r_pwy  <= r_wy * r_vy;
            r_pux  <= r_ux * r_vx;
            r_puy  <= r_uy * r_vy;
            r_pc1  <= r_vx * r_wy;
            r_pc2  <= r_vy * r_wx;
            r_wx2  <= ccs_pkg::SW'(r_wx * r_wx);
            r_wy2  <= ccs_pkg::SW'(r_wy * r_wy);
            r_ux2  <= ccs_pkg::SW'(r_ux * r_ux);
            r_uy2  <= ccs_pkg::SW'(r_uy * r_uy);
            r_vx2  <= ccs_pkg::SW'(r_vx * r_vx);
            r_vy2  <= ccs_pkg::SW'(r_vy * r_vy);
            r_rad2 <= r_rad1;

            r_s1     <= r_wx2 + r_wy2;
            r_s2     <= r_ux2 + r_uy2;
            r_vv     <= r_vx2 + r_vy2;
            r_cmag   <= ccs_pkg::SW'(n_cabs);
            r_inside <= !n_dot1[ccs_pkg::PW] && (n_dot2[ccs_pkg::PW] || n_dot2 == '0);
            r_rad3   <= r_rad2;

            r_smin    <= (r_s1 <= r_s2) ? r_s1 : r_s2;
            r_inside4 <= r_inside && (r_vv != '0);
            r_den4    <= (r_inside && (r_vv != '0)) ? r_vv : ccs_pkg::SW'(1);
            r_ch2     <= r_cmag[ccs_pkg::SW-1:ccs_pkg::CHL] * r_cmag[ccs_pkg::SW-1:ccs_pkg::CHL];
            r_chcl    <= r_cmag[ccs_pkg::SW-1:ccs_pkg::CHL] * r_cmag[ccs_pkg::CHL-1:0];
            r_cl2     <= r_cmag[ccs_pkg::CHL-1:0] * r_cmag[ccs_pkg::CHL-1:0];
            r_rad4    <= r_rad3;

            r_num  <= r_inside4 ? n_cnum : ccs_pkg::NW'(r_smin);
            r_den  <= r_den4;
            r_rad5 <= r_rad4;
        end
    end

    always_comb begin
        o_root.valid = r_v[4];
        o_root.rem   = r_num;
        o_root.dacc  = '0;
        o_root.den   = r_den;
        o_root.root  = '0;
        o_root.rad   = r_rad5;
    end

endmodule

/* rtl/core/ccs_cell.sv */
// One root cell: settles a single bit of the floor square root of num/den.
// Uses ccs_pkg. Chained by the top level, most significant bit first.
module ccs_cell #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ccs_pkg::t_root i_root,
    output ccs_pkg::t_root o_root
);

    ccs_pkg::t_root r_root;
    ccs_pkg::t_root n_root;
    logic [ccs_pkg::DELW-1:0] n_delta;

    always_comb begin
        n_delta = ({{(ccs_pkg::DELW-ccs_pkg::DAW){1'b0}}, i_root.dacc} << (BIT + 1))
                + ({{(ccs_pkg::DELW-ccs_pkg::SW){1'b0}}, i_root.den} << (2 * BIT));
        n_root = i_root;
        if (n_delta <= {{(ccs_pkg::DELW-ccs_pkg::NW){1'b0}}, i_root.rem}) begin
            n_root.rem  = i_root.rem - n_delta[ccs_pkg::NW-1:0];
            n_root.dacc = i_root.dacc
                        + ({{(ccs_pkg::DAW-ccs_pkg::SW){1'b0}}, i_root.den} << BIT);
            n_root.root = i_root.root | (ccs_pkg::RB'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root.valid <= 1'b0;
        end else if (i_en) begin
            r_root.valid <= n_root.valid;
        end
        if (i_en) begin
            r_root.rem  <= n_root.rem;
            r_root.dacc <= n_root.dacc;
            r_root.den  <= n_root.den;
            r_root.root <= n_root.root;
            r_root.rad  <= n_root.rad;
        end
    end

    assign o_root = r_root;

endmodule

/* rtl/core/circle_segment_collision.sv */
// Top level of the circle against segment distance pipeline.
// Uses ccs_pkg, ccs_front and ccs_cell.
// One transaction is accepted per cycle unless o_stall is high; each result
// passes through five front stages for products and the squared numerator, one
// cell per root bit over 26 bits, and the output register. A stall on the
// output freezes the whole pipeline while a result waits, so o_stall follows
// i_stall whenever the output register is full.
module circle_segment_collision (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  ccs_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output ccs_pkg::t_out o_data
);

    logic w_en;
    ccs_pkg::t_root w_chain [ccs_pkg::RB:0];
    ccs_pkg::t_root w_last;
    logic r_valid;
    ccs_pkg::t_out r_data;
    logic [ccs_pkg::RB-1:0] w_rad;

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_root  (w_chain[0])
    );

    for (genvar g = 0; g < ccs_pkg::RB; g++) begin : g_cell
        ccs_cell #(
            .BIT (ccs_pkg::RB - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_root  (w_chain[g]),
            .o_root  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[ccs_pkg::RB];
    assign w_rad  = ccs_pkg::RB'(w_last.rad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_last.valid;
        end
    end

    // exact distance <= radius: root below it, or equal with zero remainder
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data.distance <= w_last.root[ccs_pkg::OW-1:0];
            r_data.collided <= (w_last.root < w_rad)
                            || ((w_last.root == w_rad) && (w_last.rem == '0));
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* sim/tb_circle_segment_collision.sv */
// Self-checking testbench for circle_segment_collision: directed table then random
// transactions, checked against typed results or an exact-integer distance predictor.
// Depends on ccs_pkg and the circle_segment_collision RTL.
module tb_circle_segment_collision;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 540;

    typedef struct {
        ccs_pkg::t_in  data;
        bit            typed;
        ccs_pkg::t_out result;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    ccs_pkg::t_in   i_data = '0;
    logic  o_stall;
    logic  o_valid;
    ccs_pkg::t_out  o_data;

    ccs_pkg::t_out  pending_results[$];
    t_row  table_rows[$];
    int    errors = 0;
    int    checked = 0;
    int    hits = 0;
    int    cycles = 0;
    int    stall_pct = 0;
    int    hold_cycles = 0;

    circle_segment_collision i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [127:0] sum_sq(longint a, longint b);
        return 128'(a * a) + 128'(b * b);
    endfunction

    function automatic ccs_pkg::t_out predict_distance(ccs_pkg::t_in t);
        longint px, py, ax, ay, bx, by, vx, vy, wx, wy, ux, uy, d1, d2, cr;
        logic [127:0] num, den, s1, s2, rq;
        logic [25:0]  root, trial;
        ccs_pkg::t_out r;
        px = longint'(t.point_x);     py = longint'(t.point_y);
        ax = longint'(t.seg_start_x); ay = longint'(t.seg_start_y);
        bx = longint'(t.seg_end_x);   by = longint'(t.seg_end_y);
        vx = bx - ax; vy = by - ay;
        wx = px - ax; wy = py - ay;
        ux = px - bx; uy = py - by;
        den = 128'd1;
        if (vx != 0 || vy != 0) begin
            d1 = wx * vx + wy * vy;
            d2 = -(ux * vx) - (uy * vy);
            if (d1 >= 0 && d2 >= 0) begin
                cr = vx * wy - vy * wx;
                if (cr < 0) cr = -cr;
                num = 128'(cr) * 128'(cr);
                den = sum_sq(vx, vy);
            end else begin
                s1 = sum_sq(wx, wy);
                s2 = sum_sq(ux, uy);
                num = (s1 <= s2) ? s1 : s2;
            end
        end else begin
            num = sum_sq(wx, wy);
        end
        root = '0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (26'd1 << b);
            if (128'(trial) * 128'(trial) * den <= num) root = trial;
        end
        rq = 128'(t.circle_radius) * 128'(t.circle_radius) * den;
        r.distance = root[ccs_pkg::OW-1:0];
        r.collided = (num <= rq);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", o_data.distance, -1);
            end else begin
                ccs_pkg::t_out want;
                want = pending_results.pop_front();
                if (o_data.distance !== want.distance)
                    report_mismatch("distance", o_data.distance, want.distance);
                if (o_data.collided !== want.collided)
                    report_mismatch("collided", o_data.collided, want.collided);
                checked++;
                if (want.collided) hits++;
            end
        end
    end

    task automatic send_txn(ccs_pkg::t_in d, ccs_pkg::t_out want, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
    endtask

    function automatic ccs_pkg::t_in mk(int px, int py, int ax, int ay, int bx, int by,
                                        int rad);
        ccs_pkg::t_in t;
        t.point_x = ccs_pkg::CB'(px);     t.point_y = ccs_pkg::CB'(py);
        t.seg_start_x = ccs_pkg::CB'(ax); t.seg_start_y = ccs_pkg::CB'(ay);
        t.seg_end_x = ccs_pkg::CB'(bx);   t.seg_end_y = ccs_pkg::CB'(by);
        t.circle_radius = ccs_pkg::CB'(rad);
        return t;
    endfunction

    function automatic void add_row(ccs_pkg::t_in d, bit typed, int dist_val, bit col);
        t_row r;
        r.data = d;
        r.typed = typed;
        r.result.distance = ccs_pkg::OW'(dist_val);
        r.result.collided = col;
        table_rows.push_back(r);
    endfunction

    function automatic logic [ccs_pkg::CB-1:0] rand_coord(logic [ccs_pkg::CB-1:0] base,
                                                          int span);
        return base + ccs_pkg::CB'($urandom_range(2 * span) - span);
    endfunction

    function automatic ccs_pkg::t_in random_item();
        ccs_pkg::t_in t;
        logic [ccs_pkg::CB-1:0] base;
        int span;
        ccs_pkg::t_out p;
        span = ($urandom_range(3) == 0) ? 8388607 : (1 << $urandom_range(4, 14));
        base = ccs_pkg::CB'($urandom);
        t.point_x = rand_coord(base, span);
        t.point_y = rand_coord(base, span);
        t.seg_start_x = rand_coord(base, span);
        t.seg_start_y = rand_coord(base, span);
        if ($urandom_range(9) == 0) begin
            t.seg_end_x = t.seg_start_x;
            t.seg_end_y = t.seg_start_y;
        end else begin
            t.seg_end_x = rand_coord(base, span);
            t.seg_end_y = rand_coord(base, span);
        end
        t.circle_radius = ccs_pkg::CB'($urandom);
        if ($urandom_range(1) == 0) begin
            p = predict_distance(t);
            t.circle_radius = ccs_pkg::CB'(p.distance) + ccs_pkg::CB'($urandom_range(2))
                            - ccs_pkg::CB'(1);
        end
        return t;
    endfunction

    initial begin
        ccs_pkg::t_in d;
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        add_row(mk(0, 0, 0, 0, 0, 0, 0), 1, 0, 1);
        add_row(mk(768, 1024, 0, 0, 0, 0, 1280), 1, 1280, 1);
        add_row(mk(768, 1024, 0, 0, 0, 0, 1279), 1, 1280, 0);
        add_row(mk(1280, 768, 0, 0, 2560, 0, 768), 1, 768, 1);
        add_row(mk(3328, 0, 0, 0, 2560, 0, 767), 1, 768, 0);
        add_row(mk(0, 512, -256, 0, 256, 0, 512), 1, 512, 1);
        add_row(mk(256, 256, 0, 0, 0, 0, 362), 1, 362, 0);
        add_row(mk(256, 256, 0, 0, 0, 0, 363), 1, 362, 1);
        add_row(mk(-2560, 700, -2560, 700, 999, -31, 0), 1, 0, 1);
        add_row(mk(0, -1280, -2560, -256, 2560, -256, 1023), 1, 1024, 0);
        add_row(mk(mn, mn, mn, mn, mn, mn, 0), 1, 0, 1);
        add_row(mk(mx, mx, mn, mn, mn, mn, 16777215), 0, 0, 0);
        add_row(mk(mn, mn, mx, mn, mx, mx, 16777215), 0, 0, 0);
        add_row(mk(mn, mx, mn, mn, mx, mx, 0), 0, 0, 0);
        add_row(mk(mx, mn, mn, mx, mx, mn, 12345678), 0, 0, 0);
        add_row(mk(0, mx, mn, 0, mx, 0, mx), 0, 0, 0);
        add_row(mk(-1, -1, 1, 1, -1, 1, 1), 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct = 67;
        foreach (table_rows[k])
            send_txn(table_rows[k].data,
                     table_rows[k].typed ? table_rows[k].result
                                         : predict_distance(table_rows[k].data), 30);

        for (int phase = 0; phase < 3; phase++) begin
            int idle_pct;
            idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 67 : 0;
            stall_pct = (phase == 0) ? 67 : (phase == 1) ? 30 : 0;
            if (phase == 2) hold_cycles = 300;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                d = random_item();
                send_txn(d, predict_distance(d), idle_pct);
            end
            i_valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        $display("Checked %0d transactions (%0d collisions) across directed extremes,",
                 checked, hits);
        $display("degenerate segments and random stall/idle mixes, incl. a 300-cycle backpressure hold.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
